### src/newton_bisection_root_finder_unit_assert.svh
// Assertion macros for the root finder
`ifndef NEWTON_BISECTION_ROOT_FINDER_UNIT_ASSERT_SVH
`define NEWTON_BISECTION_ROOT_FINDER_UNIT_ASSERT_SVH
// property must hold every cycle out of reset
`define NBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nbr check failed");
// antecedent implies consequent in the next cycle
`define NBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nbr check failed");
`endif

### src/nbr_pkg.sv
package nbr_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_X_TOL     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_F_TOL     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_EVALS = 2'd2;

  localparam logic [1:0] ST_EVAL      = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_OUT_ITER  = 2'd2;
  localparam logic [1:0] ST_BAD_START = 2'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SLOW  = 6'b000010,
    S_DIV   = 6'b000100,
    S_NEWT  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;
endpackage

### src/nbr_if.sv
interface nbr_req_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic         req_type;
  logic [W-1:0] lower_x;
  logic [W-1:0] upper_x;
  logic [W-1:0] lower_f;
  logic [W-1:0] upper_f;
  logic [W-1:0] guess_x;
  logic [W-1:0] f_value;
  logic [W-1:0] df_value;
  modport source (output valid, req_type, lower_x, upper_x, lower_f, upper_f,
                  guess_x, f_value, df_value, input ready);
  modport sink (input valid, req_type, lower_x, upper_x, lower_f, upper_f,
                guess_x, f_value, df_value, output ready);
endinterface

interface nbr_res_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [1:0]   status;
  logic [W-1:0] x_out;
  logic [7:0]   eval_count;
  modport source (output valid, status, x_out, eval_count, input ready);
  modport sink (input valid, status, x_out, eval_count, output ready);
endinterface

interface nbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/newton_bisection_root_finder_unit.sv
// Bracketed Newton/bisection root finder, signed fixed point (FRAC_BITS fraction
// bits). One request at a time; req.ready stays low until the result held in the
// output register has been taken. The result register loads at the accepting
// edge for a start or an evaluation while idle, at the next edge (in S_OUT) when
// |f| is already inside f_tol, in S_FIN after the S_SLOW slowness test when the
// step bisects, and in S_FIN after S_SLOW, S_DIV and S_NEWT when a Newton step is
// tried. One shared shift-and-add unit does the work: in S_SLOW it forms
// |prev step|*|f'| one multiplier bit per cycle, then in S_DIV it runs the
// restoring division (|f| << FRAC_BITS)/|f'| one quotient bit per cycle.
module newton_bisection_root_finder_unit import nbr_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  nbr_req_if.sink   req,
  nbr_res_if.source res,
  nbr_cfg_if.sink   cfg
);
  localparam int W  = VALUE_WIDTH;
  localparam int NW = W + FRAC_BITS;       // dividend / quotient width
  localparam int DW = W + NW;              // {remainder, dividend}; holds the product too
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  state_e state_q, state_d;
  logic [30:0] x_tol_q, f_tol_q;
  logic [7:0]  max_evals_q;
  logic signed [W-1:0] root_q, lo_q, hi_q, lof_q, ns_q, nsp_q;
  logic [7:0] evals_q;
  logic       run_q;
  logic signed [W-1:0] f_q, df_q;
  logic [W-1:0] fm_q, dfm_q;
  // shared shift/add unit
  logic [DW-1:0] acc_q, opa_q;
  logic [W-1:0]  opb_q;
  logic [CW-1:0] cnt_q;
  logic          rvalid_q;
  logic [1:0]    rstat_q;
  logic signed [W-1:0] rx_q;
  logic [7:0]    rcnt_q;

  function automatic logic [W-1:0] magf(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] satsub(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    if (d[W] != d[W-1]) return d[W] ? VMIN : VMAX;
    return d[W-1:0];
  endfunction

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == S_IDLE) && !rvalid_q;
  assign res.valid = rvalid_q;
  assign res.status = rstat_q;
  assign res.x_out = rx_q;
  assign res.eval_count = rcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_tol_q <= 31'd66;
      f_tol_q <= 31'd66;
      max_evals_q <= 8'd100;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_X_TOL:     x_tol_q <= cfg.data[30:0];
        CFG_F_TOL:     f_tol_q <= cfg.data[30:0];
        CFG_MAX_EVALS: max_evals_q <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Newton candidate, evaluated after division
  logic [DW-1:0] q_w;
  logic signed [W-1:0] step_w, xn_w, half_w;
  logic [W:0] diff_w;
  logic neg_w, outb_w;
  always_comb begin
    q_w = DW'(acc_q[NW-1:0]);   // quotient lives in acc after division
    neg_w = f_q[W-1] != df_q[W-1];
    if (neg_w) begin
      step_w = (q_w > DW'({1'b1, {(W-1){1'b0}}})) ? VMIN : W'(-q_w);
    end else begin
      step_w = (q_w > DW'(VMAX)) ? VMAX : W'(q_w);
    end
    xn_w = satsub(root_q, step_w);
    outb_w = (xn_w < lo_q) || (xn_w > hi_q);
    diff_w = {hi_q[W-1], hi_q} - {lo_q[W-1], lo_q};
    half_w = (hi_q >= lo_q) ? W'(diff_w >> 1) : '0;
  end

  // remainder stays below the divisor, so the shifted remainder fits in W bits
  logic [W:0] trial_w;
  always_comb trial_w = {1'b0, acc_q[DW-2 -: W]} - {1'b0, opb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q <= 1'b0;
      evals_q <= '0;
      rvalid_q <= 1'b0;
      root_q <= '0; lo_q <= '0; hi_q <= '0; lof_q <= '0; ns_q <= '0; nsp_q <= '0;
      f_q <= '0; df_q <= '0; fm_q <= '0; dfm_q <= '0;
      acc_q <= '0; opa_q <= '0; opb_q <= '0; cnt_q <= '0;
      rstat_q <= ST_EVAL; rx_q <= '0; rcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (rvalid_q && res.ready) rvalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req.valid && req.ready) begin
          if (req.req_type == REQ_START) begin
            run_q <= 1'b0;
            evals_q <= '0;
            rvalid_q <= 1'b1;
            rcnt_q <= '0;
            if ($signed(req.guess_x) < $signed(req.lower_x) ||
                $signed(req.guess_x) > $signed(req.upper_x)) begin
              rstat_q <= ST_BAD_START; rx_q <= '0;
            end else if (magf(req.lower_f) < W'(f_tol_q)) begin
              rstat_q <= ST_CONVERGED; rx_q <= req.lower_x;
            end else if (magf(req.upper_f) < W'(f_tol_q)) begin
              rstat_q <= ST_CONVERGED; rx_q <= req.upper_x;
            end else begin
              root_q <= req.guess_x; lo_q <= req.lower_x; hi_q <= req.upper_x;
              lof_q <= req.lower_f;
              ns_q <= satsub(req.lower_x, req.upper_x);
              nsp_q <= satsub(req.lower_x, req.upper_x);
              rx_q <= req.guess_x;
              if (max_evals_q == 0) rstat_q <= ST_OUT_ITER;
              else begin
                rstat_q <= ST_EVAL; run_q <= 1'b1;
              end
            end
          end else if (!run_q) begin
            rvalid_q <= 1'b1; rstat_q <= ST_BAD_START; rx_q <= '0; rcnt_q <= evals_q;
          end else begin
            f_q <= req.f_value; df_q <= req.df_value;
            fm_q <= magf(req.f_value); dfm_q <= magf(req.df_value);
            evals_q <= evals_q + 8'd1;
            if (req.f_value[W-1] != lof_q[W-1]) hi_q <= root_q;
            else begin
              lo_q <= root_q; lof_q <= req.f_value;
            end
            // product |prev step| * |f'| by shift-add
            acc_q <= '0;
            opa_q <= DW'(magf(nsp_q));
            opb_q <= magf(req.df_value);
            cnt_q <= CW'(W);
          end
        end
        S_SLOW: begin
          if (cnt_q != 0) begin
            if (opb_q[0]) acc_q <= acc_q + opa_q;
            opa_q <= opa_q << 1;
            opb_q <= opb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            nsp_q <= ns_q;
            // set up restoring divide of fm << FRAC_BITS by dfm
            acc_q <= {{W{1'b0}}, fm_q, {FRAC_BITS{1'b0}}};
            opb_q <= dfm_q;
            cnt_q <= CW'(NW);
          end
        end
        S_DIV: if (cnt_q != 0) begin
          // acc_q holds {remainder, dividend bits still to go, quotient so far}
          if (!trial_w[W]) begin
            acc_q <= {trial_w[W-1:0], acc_q[NW-2:0], 1'b1};
          end else begin
            acc_q <= {acc_q[DW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
        end
        S_NEWT: begin
          if (outb_w) begin
            ns_q <= -half_w; root_q <= lo_q + half_w;
          end else begin
            ns_q <= step_w; root_q <= xn_w;
          end
        end
        S_FIN: begin
          rvalid_q <= 1'b1;
          rx_q <= root_q;
          rcnt_q <= evals_q;
          if (magf(ns_q) < W'(x_tol_q)) begin
            rstat_q <= ST_CONVERGED; run_q <= 1'b0;
          end else if (evals_q >= max_evals_q) begin
            rstat_q <= ST_OUT_ITER; run_q <= 1'b0;
          end else rstat_q <= ST_EVAL;
        end
        S_OUT: begin
          // converged on f before stepping
          rvalid_q <= 1'b1; rx_q <= root_q; rcnt_q <= evals_q;
          rstat_q <= ST_CONVERGED; run_q <= 1'b0;
        end
        default: ;
      endcase
      // bisection directly after slowness test
      if (state_q == S_SLOW && cnt_q == 0 &&
          (df_q == 0 || ((DW'(fm_q) << (FRAC_BITS + 1)) > acc_q))) begin
        ns_q <= -half_w; root_q <= lo_q + half_w;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req.valid && req.ready && req.req_type == REQ_EVAL && run_q) begin
        state_d = (magf(req.f_value) < W'(f_tol_q)) ? S_OUT : S_SLOW;
      end
      S_SLOW: if (cnt_q == 0) begin
        state_d = (df_q == 0 || ((DW'(fm_q) << (FRAC_BITS + 1)) > acc_q)) ? S_FIN : S_DIV;
      end
      S_DIV:  if (cnt_q == 0) state_d = S_NEWT;
      S_NEWT: state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

`include "newton_bisection_root_finder_unit_assert.svh"
  `NBR_ASSERT(a_onehot, $onehot(state_q))
  `NBR_ASSERT(a_busy_not_ready, (state_q == S_IDLE) || !req.ready)
  `NBR_ASSERT_NEXT(a_fin_result, state_q == S_FIN, rvalid_q && state_q == S_IDLE)
  `NBR_ASSERT_NEXT(a_div_done, state_q == S_DIV && cnt_q == 0, state_q == S_NEWT)
endmodule

### tb/newton_bisection_root_finder_unit_tb.sv
module newton_bisection_root_finder_unit_tb import nbr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;
  localparam int StallLimit = 6000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] lower_x;
    logic [31:0] upper_x;
    logic [31:0] lower_f;
    logic [31:0] upper_f;
    logic [31:0] guess_x;
    logic [31:0] f_value;
    logic [31:0] df_value;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] x_out;
    logic [7:0]  eval_count;
  } answer_t;

  class root_scoreboard;
    longint unsigned x_tol, f_tol;
    int unsigned max_evals;
    longint root_now, lo_end, hi_end, lo_fval, neg_step, neg_step_prev;
    int unsigned evals_done;
    bit running;
    answer_t pending[$];
    int mismatches;
    int converged, out_of_iter, bad_start, answers;

    function new();
      x_tol = 66; f_tol = 66; max_evals = 100;
      root_now = 0; lo_end = 0; hi_end = 0; lo_fval = 0;
      neg_step = 0; neg_step_prev = 0; evals_done = 0; running = 0;
      mismatches = 0; converged = 0; out_of_iter = 0; bad_start = 0; answers = 0;
    endfunction

    function longint magn(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint sat_diff(longint a, longint b);
      longint r;
      r = a - b;
      if (r > ValMax) r = ValMax;
      if (r < ValMin) r = ValMin;
      return r;
    endfunction

    function void push(logic [1:0] st, longint x, int unsigned cnt);
      answer_t a;
      a.status = st;
      a.x_out = x[31:0];
      a.eval_count = cnt[7:0];
      pending.push_back(a);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == CFG_X_TOL) x_tol = {33'd0, data[30:0]};
      else if (idx == CFG_F_TOL) f_tol = {33'd0, data[30:0]};
      else if (idx == CFG_MAX_EVALS) max_evals = data[7:0];
    endfunction

    function void note_request(request_t r);
      longint lo, hi, flo, fhi, g, f, df, x, step;
      longint unsigned fm, dfm, q, half;
      bit slow, bisect, neg;
      if (r.req_type == REQ_START) begin
        lo = $signed(r.lower_x); hi = $signed(r.upper_x);
        flo = $signed(r.lower_f); fhi = $signed(r.upper_f);
        g = $signed(r.guess_x);
        running = 0;
        evals_done = 0;
        if (!(lo <= g && g <= hi)) begin push(ST_BAD_START, 0, 0); return; end
        if (magn(flo) < f_tol) begin push(ST_CONVERGED, lo, 0); return; end
        if (magn(fhi) < f_tol) begin push(ST_CONVERGED, hi, 0); return; end
        root_now = g; lo_end = lo; hi_end = hi; lo_fval = flo;
        neg_step = sat_diff(lo, hi);
        neg_step_prev = neg_step;
        if (max_evals == 0) begin push(ST_OUT_ITER, g, 0); return; end
        running = 1;
        push(ST_EVAL, g, 0);
        return;
      end
      if (!running) begin push(ST_BAD_START, 0, evals_done); return; end
      f = $signed(r.f_value); df = $signed(r.df_value);
      fm = magn(f); dfm = magn(df);
      x = root_now; step = 0;
      evals_done = (evals_done + 1) & 8'hff;
      if ((f < 0) != (lo_fval < 0)) hi_end = root_now;
      else begin lo_end = root_now; lo_fval = f; end
      if (fm < f_tol) begin
        running = 0;
        push(ST_CONVERGED, root_now, evals_done);
        return;
      end
      slow = (df == 0) || ((fm << 17) > longint'(magn(neg_step_prev)) * dfm);
      neg_step_prev = neg_step;
      bisect = slow;
      if (!slow) begin
        q = (fm << 16) / dfm;
        neg = (f < 0) != (df < 0);
        if (neg) begin
          if (q > 64'd2147483648) q = 64'd2147483648;
          step = -longint'(q);
        end else begin
          if (q > 64'd2147483647) q = 64'd2147483647;
          step = longint'(q);
        end
        x = sat_diff(root_now, step);
        if (!(lo_end <= x && x <= hi_end)) bisect = 1;
      end
      if (bisect) begin
        half = 0;
        if (hi_end >= lo_end) half = longint'(hi_end - lo_end) >> 1;
        step = -longint'(half);
        x = lo_end + longint'(half);
      end
      neg_step = step;
      root_now = x;
      if (magn(neg_step) < x_tol) begin
        running = 0;
        push(ST_CONVERGED, root_now, evals_done);
      end else if (evals_done >= max_evals) begin
        running = 0;
        push(ST_OUT_ITER, root_now, evals_done);
      end else begin
        push(ST_EVAL, root_now, evals_done);
      end
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      answers++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      case (want.status)
        ST_CONVERGED: converged++;
        ST_OUT_ITER:  out_of_iter++;
        ST_BAD_START: bad_start++;
        default: ;
      endcase
      if (got.status !== want.status || got.x_out !== want.x_out ||
          got.eval_count !== want.eval_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st %0d x %h n %0d, got st %0d x %h n %0d",
                   want.status, want.x_out, want.eval_count,
                   got.status, got.x_out, got.eval_count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit steady = 0;
  int stall_cnt = 0;
  int requests = 0;
  root_scoreboard sb = new();

  nbr_req_if #(32) req ();
  nbr_res_if #(32) res ();
  nbr_cfg_if cfg ();

  newton_bisection_root_finder_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .res   (res),
    .cfg   (cfg)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res.ready <= !rst_ni ? 1'b0 : steady ? 1'b1 : ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      request_t r;
      bit moved;
      moved = 0;
      if (req.valid && req.ready) begin
        r = '{req.req_type, req.lower_x, req.upper_x, req.lower_f, req.upper_f,
              req.guess_x, req.f_value, req.df_value};
        sb.note_request(r);
        requests++;
        moved = 1;
      end
      if (res.valid && res.ready) begin
        sb.check_result('{res.status, res.x_out, res.eval_count});
        moved = 1;
      end
      if (cfg.valid && cfg.ready) begin
        sb.write_reg(cfg.index, cfg.data);
        moved = 1;
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("watchdog expired");
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(request_t r);
    while (!steady && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      req.valid = 0;
    end
    @(negedge clk_i);
    {req.req_type, req.lower_x, req.upper_x, req.lower_f, req.upper_f,
     req.guess_x, req.f_value, req.df_value} = r;
    req.valid = 1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg.index = idx; cfg.data = data; cfg.valid = 1;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid = 0;
  endtask

  task automatic set_all(logic [31:0] xt, logic [31:0] ft, logic [31:0] me);
    drain();
    write_cfg(CFG_X_TOL, xt);
    write_cfg(CFG_F_TOL, ft);
    write_cfg(CFG_MAX_EVALS, me);
  endtask

  function automatic request_t start_req(longint lo, longint hi, longint flo,
                                         longint fhi, longint g);
    request_t r;
    r = '0;
    r.req_type = REQ_START;
    r.lower_x = lo[31:0]; r.upper_x = hi[31:0];
    r.lower_f = flo[31:0]; r.upper_f = fhi[31:0]; r.guess_x = g[31:0];
    return r;
  endfunction

  function automatic request_t eval_req(longint f, longint df);
    request_t r;
    r = '0;
    r.req_type = REQ_EVAL;
    r.f_value = f[31:0]; r.df_value = df[31:0];
    return r;
  endfunction

  function automatic request_t noise_req();
    request_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         1'($urandom)};
    return r;
  endfunction

  // one bracketed run: sign change at the ends, shrinking f over the evaluations
  task automatic run_sequence();
    longint lo, hi, g, w, flo, f, df;
    int n;
    lo = longint'($signed($urandom)) >>> $urandom_range(0, 14);
    w = longint'($urandom_range(1, 32'h7fff_ffff)) >>> $urandom_range(0, 20);
    hi = lo + w;
    if (hi > ValMax) hi = ValMax;
    g = lo + longint'($urandom_range(0, 32'h7fff_ffff)) % (hi - lo + 1);
    flo = -(longint'($urandom_range(1, 32'h7fff_ffff)) >>> $urandom_range(0, 20));
    if ($urandom_range(1)) flo = -flo;
    send(start_req(lo, hi, flo, -flo, g));
    n = $urandom_range(1, 14);
    for (int i = 0; i < n; i++) begin
      f = longint'($signed($urandom)) >>> $urandom_range(i, i + 10);
      case ($urandom_range(5))
        0: df = 0;
        1: df = longint'($signed($urandom));
        default: df = longint'($signed($urandom)) >>> $urandom_range(8, 20);
      endcase
      if ($urandom_range(19) == 0) send(noise_req());
      else send(eval_req(f, df));
    end
  endtask

  task automatic random_phase(int count);
    int start_cnt;
    start_cnt = requests;
    while (requests - start_cnt < count) begin
      if ($urandom_range(9) == 0) send(noise_req());
      else run_sequence();
    end
  endtask

  initial begin
    req.valid = 0; req.req_type = REQ_START;
    req.lower_x = 0; req.upper_x = 0; req.lower_f = 0; req.upper_f = 0;
    req.guess_x = 0; req.f_value = 0; req.df_value = 0;
    cfg.valid = 0; cfg.index = CFG_X_TOL; cfg.data = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: guess outside, root at either end, idle eval, restart, extremes
    send(eval_req(100, 65536));
    send(start_req(0, 65536, -65536, 65536, -1));
    send(start_req(0, 65536, -65536, 65536, 65537));
    send(start_req(-65536, 65536, 10, 65536, 0));
    send(start_req(-65536, 65536, -65536, -5, 0));
    send(start_req(ValMin, ValMax, ValMin, ValMax, 0));
    send(eval_req(ValMax, 0));
    send(eval_req(ValMin, ValMin));
    send(start_req(ValMin, ValMax, ValMax, ValMin, ValMax));
    send(eval_req(ValMin, 1));
    send(start_req(-65536, 65536, -65536, 65536, 0));
    send(eval_req(-32768, 65536));
    send(eval_req(1000, 131072));
    send(eval_req(ValMax, ValMax));
    send(start_req(0, 0, -65536, 65536, 0));
    send(eval_req(-65536, 0));
    send(eval_req(65536, 65536));
    send(start_req(ValMin, ValMin, ValMin, ValMax, ValMin));
    send(eval_req(0, 0));

    set_all(0, 0, 0);
    send(start_req(-65536, 65536, -65536, 65536, 0));
    send(start_req(-65536, 65536, 0, 65536, 0));
    send(eval_req(5, 5));
    set_all(1, 1, 1);
    send(start_req(-65536, 65536, -65536, 65536, 0));
    send(eval_req(-300, 65536));
    send(eval_req(-300, 65536));

    set_all(32'hffff_ffff, 32'hffff_ffff, 255);
    random_phase(40);
    set_all(66, 66, 100);
    steady = 1;
    random_phase(50);
    steady = 0;
    set_all(1, 1, 255);
    random_phase(90);
    set_all($urandom_range(1, 4000), $urandom_range(1, 4000), $urandom_range(1, 20));
    random_phase(90);
    set_all(0, 0, $urandom_range(1, 8));
    random_phase(50);
    set_all($urandom, $urandom, $urandom_range(0, 255));
    random_phase(40);

    drain();
    repeat (100) @(posedge clk_i);
    $display("%0d requests, %0d results: %0d converged, %0d out of iterations, %0d rejected",
             requests, sb.answers, sb.converged, sb.out_of_iter, sb.bad_start);
    $display("tolerance and evaluation-limit settings swept from zero to full scale");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/nbr_pkg.sv
src/nbr_if.sv
src/newton_bisection_root_finder_unit.sv
tb/newton_bisection_root_finder_unit_tb.sv
